[rtl/rtpif_pkg.sv]
// Shared types and constants for the RTP H.264 I-frame filter.
package rtpif_pkg;

    localparam int unsigned TS_W     = 32;
    localparam int unsigned NAL_W    = 5;
    localparam int unsigned POS_W    = 5;
    localparam int unsigned SKIP_W   = 16;
    localparam int unsigned DATA_W   = 8;
    localparam int unsigned PDATA_W  = 32;
    localparam int unsigned PADDR_W  = 3;

    localparam logic [NAL_W-1:0] NAL_TYPE_MASK = NAL_W'((1 << NAL_W) - 1);
    localparam logic [NAL_W-1:0] NAL_IDR       = NAL_W'(5);
    localparam logic [NAL_W-1:0] NAL_SPS       = NAL_W'(7);
    localparam logic [NAL_W-1:0] NAL_PPS       = NAL_W'(8);
    localparam logic [NAL_W-1:0] NAL_STAP_A    = NAL_W'(24);
    localparam logic [NAL_W-1:0] NAL_FU_A      = NAL_W'(28);

    localparam logic [POS_W-1:0] MIN_PACKET_LEN = POS_W'(16);
    localparam logic [POS_W-1:0] TS_FIRST_POS   = POS_W'(4);
    localparam logic [POS_W-1:0] TS_LAST_POS    = POS_W'(7);
    localparam logic [POS_W-1:0] NAL_BYTE_POS   = POS_W'(12);
    localparam logic [POS_W-1:0] FU_BYTE_POS    = POS_W'(13);

    // register index, taken from paddr[2]
    localparam logic REG_SKIP_COUNT = 1'b0;
    localparam logic [SKIP_W-1:0] SKIP_COUNT_RESET = SKIP_W'(1);

    // one classified packet, front to back
    typedef struct packed {
        logic            short_pkt;
        logic            is_idr;
        logic            pass;
        logic [TS_W-1:0] timestamp;
    } pkt_req_t;

endpackage

[rtl/rtp_h264_iframe_filter_core.sv]
// A packet's decision is queued when its last byte is accepted, then popped into
// the registered outputs. Throughput: one byte per cycle while in_stall is low;
// each packet's decision request passes a QUEUE_DEPTH-entry queue; in_stall rises only when that queue is full.
// Reset (rst_n, async, active low) clears position, collected fields, I-frame
// phase and history, and sets skip_count to 1.
module rtp_h264_iframe_filter_core
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [rtpif_pkg::DATA_W-1:0]       data_byte,
    input  logic                               last_byte,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               forward,
    output logic                               is_iframe,
    output logic                               short_packet,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rtpif_pkg::PADDR_W-1:0]      paddr,
    input  logic [rtpif_pkg::PDATA_W-1:0]      pwdata,
    output logic [rtpif_pkg::PDATA_W-1:0]      prdata,
    output logic                               pready
);

    logic                          accept;
    logic                          push;
    logic                          pop;
    logic                          q_empty;
    logic                          q_full;
    rtpif_pkg::pkt_req_t           push_req;
    rtpif_pkg::pkt_req_t           head;
    logic [rtpif_pkg::SKIP_W-1:0]  skip_count_reg;
    logic                          reg_sel;

    assign pready   = 1'b1;
    assign reg_sel  = (paddr[2] == rtpif_pkg::REG_SKIP_COUNT);
    assign prdata   = reg_sel ? rtpif_pkg::PDATA_W'(skip_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_count_reg <= rtpif_pkg::SKIP_COUNT_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            skip_count_reg <= pwdata[rtpif_pkg::SKIP_W-1:0];
        end
    end

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    rtpif_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .push      (push),
        .push_req  (push_req)
    );

    rtpif_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_req (push_req),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    rtpif_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .skip_count   (skip_count_reg),
        .head         (head),
        .empty        (q_empty),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .forward      (forward),
        .is_iframe    (is_iframe),
        .short_packet (short_packet)
    );

    // a packet decision lands in the queue on the edge its last byte is taken
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_byte |=> !q_empty)
        else $error("packet request lost between front and queue");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_full && !pop))
        else $error("request pushed into full queue");

    a_short_passes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && short_packet |-> forward && !is_iframe)
        else $error("short packet not passed unparsed");

endmodule

[rtl/rtpif_front.sv]
// Byte parser: tracks position, collects timestamp and NAL types, classifies packets.
module rtpif_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               accept,
    input  logic [rtpif_pkg::DATA_W-1:0]       data_byte,
    input  logic                               last_byte,
    output logic                               push,
    output rtpif_pkg::pkt_req_t                push_req
);

    logic [rtpif_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [rtpif_pkg::TS_W-1:0]  ts_reg, ts_next;
    logic [rtpif_pkg::NAL_W-1:0] outer_reg, outer_next;
    logic [rtpif_pkg::NAL_W-1:0] inner_reg, inner_next;
    logic [rtpif_pkg::NAL_W-1:0] sel_type;
    logic                        stap;

    always_comb
    begin
        ts_next    = ts_reg;
        outer_next = outer_reg;
        inner_next = inner_reg;
        if (pos_reg >= rtpif_pkg::TS_FIRST_POS && pos_reg <= rtpif_pkg::TS_LAST_POS)
        begin
            ts_next = {ts_reg[rtpif_pkg::TS_W-rtpif_pkg::DATA_W-1:0], data_byte};
        end
        else if (pos_reg == rtpif_pkg::NAL_BYTE_POS)
        begin
            outer_next = data_byte[rtpif_pkg::NAL_W-1:0] & rtpif_pkg::NAL_TYPE_MASK;
        end
        else if (pos_reg == rtpif_pkg::FU_BYTE_POS)
        begin
            inner_next = data_byte[rtpif_pkg::NAL_W-1:0] & rtpif_pkg::NAL_TYPE_MASK;
        end

        if (last_byte)
        begin
            pos_next = '0;
        end
        else if (pos_reg < rtpif_pkg::MIN_PACKET_LEN)
        begin
            pos_next = pos_reg + 1'b1;
        end
        else
        begin
            pos_next = pos_reg;
        end
    end

    // FU-A looks at the inner type; STAP-A always passes
    always_comb
    begin
        stap     = (outer_next == rtpif_pkg::NAL_STAP_A);
        sel_type = (outer_next == rtpif_pkg::NAL_FU_A) ? inner_next : outer_next;
    end

    assign push                = accept && last_byte;
    assign push_req.short_pkt  = (pos_reg < rtpif_pkg::MIN_PACKET_LEN - 1'b1);
    assign push_req.is_idr     = !stap && (sel_type == rtpif_pkg::NAL_IDR);
    assign push_req.pass       = stap || sel_type == rtpif_pkg::NAL_IDR
                                 || sel_type == rtpif_pkg::NAL_SPS
                                 || sel_type == rtpif_pkg::NAL_PPS;
    assign push_req.timestamp  = ts_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            ts_reg    <= '0;
            outer_reg <= '0;
            inner_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg   <= pos_next;
            ts_reg    <= ts_next;
            outer_reg <= outer_next;
            inner_reg <= inner_next;
        end
    end

endmodule

[rtl/rtpif_queue.sv]
// Small FIFO of classified packet requests between parser and decision logic.
module rtpif_queue
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rtpif_pkg::pkt_req_t push_req,
    input  logic                pop,
    output rtpif_pkg::pkt_req_t head,
    output logic                empty,
    output logic                full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    rtpif_pkg::pkt_req_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/rtpif_back.sv]
// Decision stage: I-frame phase tracking and registered result output.
module rtpif_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [rtpif_pkg::SKIP_W-1:0]      skip_count,
    input  rtpif_pkg::pkt_req_t               head,
    input  logic                              empty,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              forward,
    output logic                              is_iframe,
    output logic                              short_packet
);

    logic                              out_valid_reg, out_valid_next;
    logic                              fwd_reg, fwd_next;
    logic                              idr_reg, idr_next;
    logic                              short_reg, short_next;
    logic                              seen_reg, seen_next;
    logic [rtpif_pkg::SKIP_W-1:0]      phase_reg, phase_next;
    logic [rtpif_pkg::TS_W-1:0]        last_ts_reg, last_ts_next;
    logic [rtpif_pkg::SKIP_W-1:0]      skip_eff;
    logic [rtpif_pkg::SKIP_W:0]        phase_inc;

    assign pop = !empty && (!out_valid_reg || !out_stall);

    always_comb
    begin
        skip_eff  = (skip_count == '0) ? rtpif_pkg::SKIP_W'(1) : skip_count;
        phase_inc = {1'b0, phase_reg} + 1'b1;

        out_valid_next = out_valid_reg && out_stall;
        fwd_next       = fwd_reg;
        idr_next       = idr_reg;
        short_next     = short_reg;
        seen_next      = seen_reg;
        phase_next     = phase_reg;
        last_ts_next   = last_ts_reg;

        if (pop)
        begin
            out_valid_next = 1'b1;
            short_next     = head.short_pkt;
            idr_next       = !head.short_pkt && head.is_idr;
            fwd_next       = head.short_pkt || head.pass;
            if (!head.short_pkt && head.is_idr)
            begin
                if (!seen_reg)
                begin
                    seen_next    = 1'b1;
                    phase_next   = '0;
                    last_ts_next = head.timestamp;
                end
                else if (last_ts_reg != head.timestamp)
                begin
                    // wrap also catches a phase left above a lowered skip count
                    phase_next   = (phase_inc >= {1'b0, skip_eff}) ? '0
                                   : phase_inc[rtpif_pkg::SKIP_W-1:0];
                    last_ts_next = head.timestamp;
                end
                fwd_next = (phase_next == '0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_reg   <= fwd_next;
        idr_reg   <= idr_next;
        short_reg <= short_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            seen_reg      <= 1'b0;
            phase_reg     <= '0;
            last_ts_reg   <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            seen_reg      <= seen_next;
            phase_reg     <= phase_next;
            last_ts_reg   <= last_ts_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign forward      = fwd_reg;
    assign is_iframe    = idr_reg;
    assign short_packet = short_reg;

endmodule
